>>> rtl/core/bfw_pkg.sv
// ----------------------------------------------------------------------------
// bfw_pkg
// Shared types and constants for the bilinear flow warp block.
// ----------------------------------------------------------------------------
package bfw_pkg;

  // default store geometry and fixed point
  localparam int DEF_MAX_ROWS  = 256;
  localparam int DEF_MAX_COLS  = 256;
  localparam int DEF_FRAC_BITS = 8;

  localparam int NUM_CH   = 3;
  localparam int CH_W     = 16;
  localparam int PIX_W    = NUM_CH * CH_W;
  // signed width of a whole-pixel position, then unsigned width of the size registers
  localparam int IW       = 14;
  localparam int SIZE_W   = 9;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = 2;

  // command codes of an input word
  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  // configuration register indexes
  typedef enum logic {
    REG_IMAGE_ROWS = 1'b0,
    REG_IMAGE_COLS = 1'b1
  } reg_idx_t;

  // class of a queued word
  typedef enum logic [1:0] {
    KIND_DROP   = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        row;
    logic [7:0]        col;
    logic [PIX_W-1:0]  pix;
    logic [15:0]       flow_x;
    logic [15:0]       flow_y;
  } item_t;

  // store control from the back end
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

>>> rtl/core/bfw_if.sv
// ----------------------------------------------------------------------------
// bfw_in_if / bfw_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface bfw_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  row;
  logic [7:0]  col;
  logic [15:0] load_ch0;
  logic [15:0] load_ch1;
  logic [15:0] load_ch2;
  logic [15:0] flow_x;
  logic [15:0] flow_y;

  modport source (output valid, command, row, col, load_ch0, load_ch1, load_ch2,
                  flow_x, flow_y, input ready);
  modport sink   (input valid, command, row, col, load_ch0, load_ch1, load_ch2,
                  flow_x, flow_y, output ready);
endinterface

interface bfw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_ch0;
  logic [15:0] out_ch1;
  logic [15:0] out_ch2;

  modport source (output valid, out_ch0, out_ch1, out_ch2, input ready);
  modport sink   (input valid, out_ch0, out_ch1, out_ch2, output ready);
endinterface

>>> rtl/core/bfw_front.sv
// ----------------------------------------------------------------------------
// bfw_front
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module bfw_front #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  bfw_in_if.sink        in_word,
  output bfw_pkg::item_t head,
  output logic          head_valid,
  input  logic          pop
);
  import bfw_pkg::*;

  item_t               q_mem [Q_DEPTH];
  logic [Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]       cnt_r, cnt_nxt;
  logic                push;
  logic                do_pop;
  item_t               cls;

  // classify the incoming word
  always_comb begin
    cls.row    = in_word.row;
    cls.col    = in_word.col;
    cls.pix    = {in_word.load_ch2, in_word.load_ch1, in_word.load_ch0};
    cls.flow_x = in_word.flow_x;
    cls.flow_y = in_word.flow_y;
    if (cmd_t'(in_word.command) == CMD_SAMPLE) begin
      cls.kind = KIND_SAMPLE;
    end else if ((32'(in_word.row) < 32'(MAX_ROWS)) && (32'(in_word.col) < 32'(MAX_COLS))) begin
      cls.kind = KIND_LOAD;
    end else begin
      cls.kind = KIND_DROP;
    end
  end

  assign in_word.ready = (cnt_r != (Q_AW+1)'(Q_DEPTH));
  assign push          = in_word.valid && in_word.ready;
  assign head_valid    = (cnt_r != '0);
  assign do_pop        = pop && head_valid;
  assign head          = q_mem[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> rtl/core/bfw_store.sv
// ----------------------------------------------------------------------------
// bfw_store
// Image store split in four banks by row and column parity, so that the
// four neighbors of a sample come out in one registered read.
// ----------------------------------------------------------------------------
module bfw_store #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256,
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                     clk,
  input  bfw_pkg::mem_ctl_t        ctl,
  input  logic [RW-1:0]            wr_row,
  input  logic [CW-1:0]            wr_col,
  input  logic [bfw_pkg::PIX_W-1:0] wr_data,
  input  logic [RW-1:0]            r0,
  input  logic [RW-1:0]            r1,
  input  logic [CW-1:0]            c0,
  input  logic [CW-1:0]            c1,
  output logic [bfw_pkg::PIX_W-1:0] p00,
  output logic [bfw_pkg::PIX_W-1:0] p01,
  output logic [bfw_pkg::PIX_W-1:0] p10,
  output logic [bfw_pkg::PIX_W-1:0] p11
);
  import bfw_pkg::*;

  localparam int RHW   = (RW > 1) ? RW - 1 : 1;
  localparam int CHW   = (CW > 1) ? CW - 1 : 1;
  localparam int BAW   = RHW + CHW;
  localparam int BDEPTH = 1 << BAW;

  logic [PIX_W-1:0] q_r [2][2];
  logic             rp0_r, rp1_r, cp0_r, cp1_r;
  logic [BAW-1:0]   waddr;

  assign waddr = {RHW'(wr_row >> 1), CHW'(wr_col >> 1)};

  // one bank per row and column parity
  for (genvar gr = 0; gr < 2; gr++) begin : g_row
    for (genvar gc = 0; gc < 2; gc++) begin : g_col
      logic [PIX_W-1:0] mem [BDEPTH];
      logic [RHW-1:0]   ra;
      logic [CHW-1:0]   ca;

      // each bank reads the neighbor row and column of its own parity
      always_comb begin
        ra = (r0[0] == 1'(gr)) ? RHW'(r0 >> 1) : RHW'(r1 >> 1);
        ca = (c0[0] == 1'(gc)) ? CHW'(c0 >> 1) : CHW'(c1 >> 1);
      end

      always_ff @(posedge clk) begin
        if (ctl.wr_en && (wr_row[0] == 1'(gr)) && (wr_col[0] == 1'(gc))) begin
          mem[waddr] <= wr_data;
        end
        if (ctl.rd_en) begin
          q_r[gr][gc] <= mem[{ra, ca}];
        end
      end
    end
  end

  // parities steer bank outputs back to neighbor positions
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rp0_r <= r0[0];
      rp1_r <= r1[0];
      cp0_r <= c0[0];
      cp1_r <= c1[0];
    end
  end

  assign p00 = q_r[rp0_r][cp0_r];
  assign p01 = q_r[rp0_r][cp1_r];
  assign p10 = q_r[rp1_r][cp0_r];
  assign p11 = q_r[rp1_r][cp1_r];

endmodule

>>> rtl/core/bfw_back.sv
// ----------------------------------------------------------------------------
// bfw_back
// Executes queued words: loads write the store, samples go through
// position, read, horizontal blend and vertical blend stages.
// ----------------------------------------------------------------------------
module bfw_back #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_COLS  = 256,
  parameter int FRAC_BITS = 8,
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bfw_pkg::SIZE_W-1:0] image_rows,
  input  logic [bfw_pkg::SIZE_W-1:0] image_cols,
  input  bfw_pkg::item_t             head,
  input  logic                       head_valid,
  output logic                       pop,
  output bfw_pkg::mem_ctl_t          ctl,
  output logic [RW-1:0]              wr_row,
  output logic [CW-1:0]              wr_col,
  output logic [bfw_pkg::PIX_W-1:0]  wr_data,
  output logic [RW-1:0]              r0,
  output logic [RW-1:0]              r1,
  output logic [CW-1:0]              c0,
  output logic [CW-1:0]              c1,
  input  logic [bfw_pkg::PIX_W-1:0]  p00,
  input  logic [bfw_pkg::PIX_W-1:0]  p01,
  input  logic [bfw_pkg::PIX_W-1:0]  p10,
  input  logic [bfw_pkg::PIX_W-1:0]  p11,
  bfw_out_if.source                  out_word
);
  import bfw_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int PW  = F + IW;
  localparam int WW  = F + 1;
  localparam int HW  = CH_W + F + 1;
  localparam int VW  = HW + WW + 1;
  localparam logic [VW-1:0] HALF = VW'(1) << (2 * F - 1);
  localparam logic [WW-1:0] ONE  = WW'(1) << F;

  function automatic logic signed [IW-1:0] clamp_idx(logic signed [IW-1:0] i,
                                                     logic signed [IW-1:0] n);
    logic signed [IW-1:0] res;
    if (i < 0) begin
      res = '0;
    end else if (i >= n) begin
      res = n - 1;
    end else begin
      res = i;
    end
    return res;
  endfunction

  logic adv;

  // stage 1: word out of the queue
  logic  s1_v_r;
  item_t s1_r;
  // stage 2: neighbors read, weights carried
  logic         s2_v_r;
  logic [F-1:0] tx2_r, ty2_r;
  // stage 3: horizontal blends
  logic           s3_v_r;
  logic [F-1:0]   ty3_r;
  logic [HW-1:0]  h0_r [NUM_CH];
  logic [HW-1:0]  h1_r [NUM_CH];
  logic [HW-1:0]  h0_nxt [NUM_CH];
  logic [HW-1:0]  h1_nxt [NUM_CH];
  // output register
  logic              out_v_r;
  logic [CH_W-1:0]   out_ch_r [NUM_CH];
  logic [CH_W-1:0]   out_ch_nxt [NUM_CH];

  logic signed [PW-1:0] py, px;
  logic signed [IW-1:0] fy, fx, nr, nc;
  logic [F-1:0]         ty1, tx1;

  assign adv = !out_v_r || out_word.ready;
  assign pop = adv && head_valid;

  // effective image size
  always_comb begin
    if (image_rows == '0) begin
      nr = IW'(1);
    end else if (32'(image_rows) > 32'(MAX_ROWS)) begin
      nr = IW'(MAX_ROWS);
    end else begin
      nr = IW'(image_rows);
    end
    if (image_cols == '0) begin
      nc = IW'(1);
    end else if (32'(image_cols) > 32'(MAX_COLS)) begin
      nc = IW'(MAX_COLS);
    end else begin
      nc = IW'(image_cols);
    end
  end

  // sample position, floor and clamped neighbor indices
  always_comb begin
    py  = $signed({{(IW-8){1'b0}}, s1_r.row, {F{1'b0}}})
        + $signed({{(PW-16){s1_r.flow_y[15]}}, s1_r.flow_y});
    px  = $signed({{(IW-8){1'b0}}, s1_r.col, {F{1'b0}}})
        + $signed({{(PW-16){s1_r.flow_x[15]}}, s1_r.flow_x});
    fy  = py[PW-1:F];
    fx  = px[PW-1:F];
    ty1 = py[F-1:0];
    tx1 = px[F-1:0];
    r0  = RW'(clamp_idx(fy, nr));
    r1  = RW'(clamp_idx(fy + IW'(1), nr));
    c0  = CW'(clamp_idx(fx, nc));
    c1  = CW'(clamp_idx(fx + IW'(1), nc));
  end

  // store access
  assign ctl.wr_en = adv && s1_v_r && (s1_r.kind == KIND_LOAD);
  assign ctl.rd_en = adv && s1_v_r && (s1_r.kind == KIND_SAMPLE);
  assign wr_row    = RW'(s1_r.row);
  assign wr_col    = CW'(s1_r.col);
  assign wr_data   = s1_r.pix;

  // horizontal blend per channel
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      h0_nxt[k] = HW'(HW'(p00[k*CH_W +: CH_W]) * HW'(ONE - WW'(tx2_r)))
                + HW'(HW'(p01[k*CH_W +: CH_W]) * HW'(tx2_r));
      h1_nxt[k] = HW'(HW'(p10[k*CH_W +: CH_W]) * HW'(ONE - WW'(tx2_r)))
                + HW'(HW'(p11[k*CH_W +: CH_W]) * HW'(tx2_r));
    end
  end

  // vertical blend, round half up, saturate
  always_comb begin
    logic [VW-1:0] v;
    logic [VW-1:0] q;
    v = '0;
    q = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      v = VW'(VW'(h0_r[k]) * VW'(ONE - WW'(ty3_r))) + VW'(VW'(h1_r[k]) * VW'(ty3_r));
      q = (v + HALF) >> (2 * F);
      out_ch_nxt[k] = (q > VW'(16'hFFFF)) ? 16'hFFFF : CH_W'(q);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= head_valid;
      s2_v_r  <= s1_v_r && (s1_r.kind == KIND_SAMPLE);
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= head;
      tx2_r <= tx1;
      ty2_r <= ty1;
      ty3_r <= ty2_r;
      for (int k = 0; k < NUM_CH; k++) begin
        h0_r[k]     <= h0_nxt[k];
        h1_r[k]     <= h1_nxt[k];
        out_ch_r[k] <= out_ch_nxt[k];
      end
    end
  end

  assign out_word.valid   = out_v_r;
  assign out_word.out_ch0 = out_ch_r[0];
  assign out_word.out_ch1 = out_ch_r[1];
  assign out_word.out_ch2 = out_ch_r[2];

endmodule

>>> rtl/core/bilinear_flow_warp.sv
// ----------------------------------------------------------------------------
// bilinear_flow_warp
// Warps a stored three-channel image by per-pixel flow with bilinear blend.
//
//   channel  dir  handshake      word
//   in_word  in   valid/ready    command, row, col, load_ch0..2, flow_x/y
//   out_word out  valid/ready    out_ch0..2, one per sample
//   cfg_*    in   write enable   image_rows, image_cols
//
// One word is taken per cycle while the queue has room; a sample's result
// is registered in turn by the queue, the banked store read, the horizontal
// blend and the vertical blend, and waits there while the result is stalled.
// The four-bank store delivers all four neighbors in one read per unstalled cycle.
// Synchronous reset clears control and sets the size registers to 256; the image store
// holds nothing defined until loaded and needs no clearing pass.
// A stalled result freezes the back end; the front queue keeps taking words
// until its four entries are full.
// ----------------------------------------------------------------------------
module bilinear_flow_warp #(
  parameter int MAX_ROWS  = bfw_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = bfw_pkg::DEF_MAX_COLS,
  parameter int FRAC_BITS = bfw_pkg::DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bfw_in_if.sink                     in_word,
  bfw_out_if.source                  out_word,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bfw_pkg::SIZE_W-1:0] cfg_data
);
  import bfw_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [SIZE_W-1:0] rows_r, cols_r;
  item_t             head;
  logic              head_valid;
  logic              pop;
  mem_ctl_t          ctl;
  logic [RW-1:0]     wr_row, r0, r1;
  logic [CW-1:0]     wr_col, c0, c1;
  logic [PIX_W-1:0]  wr_data, p00, p01, p10, p11;

  // size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SIZE_W'(256);
      cols_r <= SIZE_W'(256);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_IMAGE_ROWS: rows_r <= cfg_data;
        REG_IMAGE_COLS: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bfw_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .clk, .rst_n, .in_word, .head, .head_valid, .pop
  );

  bfw_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .image_rows(rows_r), .image_cols(cols_r), .head, .head_valid, .pop,
    .ctl, .wr_row, .wr_col, .wr_data, .r0, .r1, .c0, .c1,
    .p00, .p01, .p10, .p11, .out_word
  );

  bfw_store #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_store (
    .clk, .ctl, .wr_row, .wr_col, .wr_data, .r0, .r1, .c0, .c1,
    .p00, .p01, .p10, .p11
  );

  // a load and a sample never touch the store in the same cycle
  a_wr_rd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.wr_en && ctl.rd_en)) else $error("store write and read together");

  // the queue only hands over a word when it holds one
  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("pop from empty queue");

  // reset leaves no result pending
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_word.valid) else $error("result valid after reset");

endmodule

>>> tb/bilinear_flow_warp_test.sv
// ----------------------------------------------------------------------------
// bilinear_flow_warp_test
// Self-checking bench for the bilinear flow warp block. It loads images of
// several sizes, sends samples with directed and random flow vectors, and
// checks each result word against a bilinear predictor. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module bilinear_flow_warp_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bfw_pkg::*;

  localparam int STORE_ROWS = 256;
  localparam int STORE_COLS = 256;
  localparam int FB         = 8;
  localparam int CYCLE_CAP  = 100000;

  typedef struct {
    logic [15:0] ch0;
    logic [15:0] ch1;
    logic [15:0] ch2;
  } warp_pix_t;

  // predictor of the warp and queue of pending warped pixels
  class warp_scoreboard;
    logic [47:0] pixel_mem [STORE_ROWS*STORE_COLS];
    int unsigned rows_reg;
    int unsigned cols_reg;
    warp_pix_t   pending_pix[$];
    int          mismatches;

    function new();
      rows_reg   = 256;
      cols_reg   = 256;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, int unsigned val);
      if (idx == REG_IMAGE_ROWS) rows_reg = val & 9'h1ff;
      else cols_reg = val & 9'h1ff;
    endfunction

    function int unsigned eff(int unsigned v, int unsigned mx);
      if (v == 0) return 1;
      if (v > mx) return mx;
      return v;
    endfunction

    function longint clampi(longint i, longint n);
      if (i < 0) return 0;
      if (i >= n) return n - 1;
      return i;
    endfunction

    // note one accepted input word
    function void note_word(cmd_t cmd, logic [7:0] row, logic [7:0] col,
                            logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                            logic [15:0] fx, logic [15:0] fy);
      longint    nr, nc, py, px, fyi, fxi, r0, r1, q0, q1;
      longint    ty, tx, p00, p01, p10, p11, h0, h1, v;
      warp_pix_t res;
      logic [15:0] outs [3];
      if (cmd == CMD_LOAD) begin
        pixel_mem[{row, col}] = {c2, c1, c0};
        return;
      end
      nr  = eff(rows_reg, STORE_ROWS);
      nc  = eff(cols_reg, STORE_COLS);
      py  = (longint'(row) <<< FB) + longint'($signed(fy));
      px  = (longint'(col) <<< FB) + longint'($signed(fx));
      fyi = py >>> FB;
      fxi = px >>> FB;
      ty  = py & ((1 << FB) - 1);
      tx  = px & ((1 << FB) - 1);
      r0  = clampi(fyi, nr);
      r1  = clampi(fyi + 1, nr);
      q0  = clampi(fxi, nc);
      q1  = clampi(fxi + 1, nc);
      for (int k = 0; k < 3; k++) begin
        p00 = (pixel_mem[r0*STORE_COLS + q0] >> (16*k)) & 16'hffff;
        p01 = (pixel_mem[r0*STORE_COLS + q1] >> (16*k)) & 16'hffff;
        p10 = (pixel_mem[r1*STORE_COLS + q0] >> (16*k)) & 16'hffff;
        p11 = (pixel_mem[r1*STORE_COLS + q1] >> (16*k)) & 16'hffff;
        h0  = p00 * ((1 << FB) - tx) + p01 * tx;
        h1  = p10 * ((1 << FB) - tx) + p11 * tx;
        v   = h0 * ((1 << FB) - ty) + h1 * ty;
        v   = (v + (longint'(1) << (2*FB - 1))) >> (2*FB);
        if (v > 16'hffff) v = 16'hffff;
        outs[k] = v[15:0];
      end
      res.ch0 = outs[0];
      res.ch1 = outs[1];
      res.ch2 = outs[2];
      pending_pix.push_back(res);
    endfunction

    // compare one result word with the oldest expected pixel
    function void check_word(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2);
      warp_pix_t e;
      if (pending_pix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word %h %h %h", a0, a1, a2);
        return;
      end
      e = pending_pix.pop_front();
      if (a0 !== e.ch0 || a1 !== e.ch1 || a2 !== e.ch2) begin
        mismatches++;
        if (mismatches <= 10)
          $display("warp mismatch: expected %h %h %h, got %h %h %h",
                   e.ch0, e.ch1, e.ch2, a0, a1, a2);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [SIZE_W-1:0] cfg_data;
  logic steady;
  int unsigned cycles = 0;

  bfw_in_if  in_if();
  bfw_out_if out_if();
  warp_scoreboard sb;

  bilinear_flow_warp u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if),
    .out_word (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stall and checking
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_word(out_if.out_ch0, out_if.out_ch1, out_if.out_ch2);
    out_if.ready <= steady ? 1'b1 : ($urandom_range(99) >= 19);
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // send one word, with a random gap first
  task automatic send_word(cmd_t cmd, logic [7:0] row, logic [7:0] col,
                           logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                           logic [15:0] fx, logic [15:0] fy);
    while (!steady && $urandom_range(99) < 19) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.command  <= cmd;
    in_if.row      <= row;
    in_if.col      <= col;
    in_if.load_ch0 <= c0;
    in_if.load_ch1 <= c1;
    in_if.load_ch2 <= c2;
    in_if.flow_x   <= fx;
    in_if.flow_y   <= fy;
    do @(posedge clk); while (!in_if.ready);
    sb.note_word(cmd, row, col, c0, c1, c2, fx, fy);
  endtask

  task automatic load_pixel(int r, int c);
    send_word(CMD_LOAD, 8'(r), 8'(c), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task automatic sample(int r, int c, int fx, int fy);
    send_word(CMD_SAMPLE, 8'(r), 8'(c), 16'($urandom), 16'($urandom), 16'($urandom),
              16'(fx), 16'(fy));
  endtask

  // wait until all results are in, with the input idle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pix.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_size(reg_idx_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= SIZE_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic load_region(int rows, int cols);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++) load_pixel(r, c);
  endtask

  // random sample: mostly near the image, some with any flow
  task automatic random_sample(int rows, int cols);
    int r, c, fx, fy;
    if ($urandom_range(3) == 0) begin
      sample($urandom_range(255), $urandom_range(255), $urandom, $urandom);
    end else begin
      r  = $urandom_range(rows + 1 > 255 ? 255 : rows + 1);
      c  = $urandom_range(cols + 1 > 255 ? 255 : cols + 1);
      fx = $urandom_range(1023) - 512;
      fy = $urandom_range(1023) - 512;
      sample(r, c, fx, fy);
    end
  endtask

  initial begin
    int rr, cc;
    sb = new();
    rst_n = 1'b0;
    steady = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_IMAGE_ROWS;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.command = CMD_LOAD;
    in_if.row = '0;
    in_if.col = '0;
    in_if.load_ch0 = '0;
    in_if.load_ch1 = '0;
    in_if.load_ch2 = '0;
    in_if.flow_x = '0;
    in_if.flow_y = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero sizes act as a one-pixel image
    write_size(REG_IMAGE_ROWS, 0);
    write_size(REG_IMAGE_COLS, 0);
    send_word(CMD_LOAD, 0, 0, 16'hffff, 16'h0000, 16'h8000, 0, 0);
    sample(0, 0, 0, 0);
    sample(255, 255, 16'h7fff, 16'h7fff);
    sample(0, 0, 16'h8000, 16'h8000);
    sample(128, 3, 16'h0080, 16'hff80);
    send_word(CMD_LOAD, 0, 0, 16'h0000, 16'hffff, 16'h0001, 0, 0);
    sample(0, 0, 16'h00ff, 16'hffff);
    drain();

    // small image, interior blends and edge clamping
    write_size(REG_IMAGE_ROWS, 3);
    write_size(REG_IMAGE_COLS, 5);
    load_region(3, 5);
    sample(1, 1, 16'h0080, 16'h0080);
    sample(2, 4, 16'h0001, 16'h00ff);
    sample(0, 0, 16'hff00, 16'hfe80);
    sample(7, 9, 0, 0);
    for (int i = 0; i < 200; i++) random_sample(3, 5);
    drain();

    // edge strips: column zero over all rows, row zero over all columns
    for (int r = 0; r < 256; r++) load_pixel(r, 0);
    for (int c = 1; c < 256; c++) load_pixel(0, c);
    // top-left block with no idling
    steady = 1'b1;
    for (int r = 1; r < 16; r++)
      for (int c = 1; c < 16; c++) load_pixel(r, c);
    steady = 1'b0;
    drain();

    // one-column, one-row and oversize settings, then small random sizes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin rr = 511; cc = 1; end
        1: begin rr = 1; cc = 300; end
        2: begin rr = 300; cc = 0; end
        default: begin rr = $urandom_range(1, 16); cc = $urandom_range(1, 16); end
      endcase
      write_size(REG_IMAGE_ROWS, rr);
      write_size(REG_IMAGE_COLS, cc);
      if (rr > 256 || rr == 0) rr = (rr == 0) ? 1 : 256;
      if (cc > 256 || cc == 0) cc = (cc == 0) ? 1 : 256;
      if (ph == 0) begin
        sample(255, 255, 16'h0080, 16'h0080);
        sample(0, 255, 16'h0100, 16'hff00);
      end
      steady = (ph == 3);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(4) == 0) load_pixel($urandom_range(255), $urandom_range(255));
        else random_sample(rr, cc);
      end
      drain();
    end

    // final settle
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_pix.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
